@@ rtl/core/ept_pkg.sv @@
// Shared types and constants for the evolving permutation table.
`timescale 1ns / 1ps

package ept_pkg;

	localparam int CMD_W   = 3;
	localparam int IDX_W   = 6;
	localparam int STEP_W  = 6;
	localparam int INV_W   = 11;
	localparam int LS_W    = 7;
	localparam int CMP_W   = 8;

	localparam logic [LS_W-1:0] LIST_SIZE_RESET = 7'd64;

	// Item kinds.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 3'd0,
		CMD_COMPARE = 3'd1,
		CMD_ASWAP   = 3'd2,
		CMD_TSWAP   = 3'd3,
		CMD_HOT     = 3'd4,
		CMD_COUNT   = 3'd5
	} cmd_t;

	// Commands from the controller to the datapath.
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOAD,
		OP_READ,
		OP_WR1,
		OP_WR2,
		OP_COUNT
	} dp_op_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             ab_ok;
		logic             step_go;
		logic             cnt_done;
	} dp_status_t;

endpackage

@@ rtl/core/ept_if.sv @@
// Valid/ready channel interfaces for items and results.
`timescale 1ns / 1ps

interface ept_in_if import ept_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [IDX_W-1:0]  index_a;
	logic [IDX_W-1:0]  index_b;
	logic              move_up;
	logic [STEP_W-1:0] steps;

	modport source (output valid, cmd, index_a, index_b, move_up, steps, input ready);
	modport sink (input valid, cmd, index_a, index_b, move_up, steps, output ready);
endinterface

interface ept_out_if import ept_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             before_res;
	logic             bad_swap;
	logic [IDX_W-1:0] final_position;
	logic [INV_W-1:0] inversions;

	modport source (output valid, before_res, bad_swap, final_position, inversions,
		input ready);
	modport sink (input valid, before_res, bad_swap, final_position, inversions,
		output ready);
endinterface

@@ rtl/core/ept_ctrl.sv @@
// Controller state machine that sequences each item through the datapath.
`timescale 1ns / 1ps

module ept_ctrl import ept_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       out_free,
	input  dp_status_t status,
	output logic       in_ready,
	output dp_op_t     op,
	output logic       done
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DISP = 7'b0000010,
		ST_READ = 7'b0000100,
		ST_WR1  = 7'b0001000,
		ST_WR2  = 7'b0010000,
		ST_CNT  = 7'b0100000,
		ST_DONE = 7'b1000000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_IDLE;
		done     = 1'b0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (status.cmd)
					CMD_LOAD:    state_d = status.ab_ok ? ST_WR1 : ST_DONE;
					CMD_COMPARE: state_d = ST_READ;
					CMD_ASWAP:   state_d = status.ab_ok ? ST_READ : ST_DONE;
					CMD_TSWAP,
					CMD_HOT:     state_d = status.step_go ? ST_READ : ST_DONE;
					CMD_COUNT:   state_d = ST_CNT;
					default:     state_d = ST_DONE;
				endcase
			end
			ST_READ: begin
				op      = OP_READ;
				state_d = (status.cmd == CMD_COMPARE) ? ST_DONE : ST_WR1;
			end
			ST_WR1: begin
				op      = OP_WR1;
				state_d = (status.cmd == CMD_LOAD) ? ST_DONE : ST_WR2;
			end
			ST_WR2: begin
				op      = OP_WR2;
				state_d = (status.cmd == CMD_ASWAP) ? ST_DONE : ST_DISP;
			end
			ST_CNT: begin
				op = OP_COUNT;
				if (status.cnt_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/ept_dp.sv @@
// Datapath: the two permutation memories, item registers, walk counters and result logic.
`timescale 1ns / 1ps

module ept_dp import ept_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_op_t            op,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [IDX_W-1:0]  index_a,
	input  logic [IDX_W-1:0]  index_b,
	input  logic              move_up,
	input  logic [STEP_W-1:0] steps,
	input  logic [LS_W-1:0]   list_size,
	output dp_status_t        status,
	output logic              before_res,
	output logic              bad_swap,
	output logic [IDX_W-1:0]  final_position,
	output logic [INV_W-1:0]  inversions
);

	localparam int N_MAX = (MAX_ITEMS < 127) ? MAX_ITEMS : 127;
	localparam int AW    = $clog2(N_MAX);
	localparam int NW    = $clog2(N_MAX + 1);
	localparam int CW    = NW + 1;

	logic [AW-1:0] tp_mem [N_MAX];
	logic [AW-1:0] sa_mem [N_MAX];

	logic [CMD_W-1:0]  cmd_q;
	logic [IDX_W-1:0]  a_raw_q;
	logic [IDX_W-1:0]  b_raw_q;
	logic              up_q;
	logic [STEP_W-1:0] steps_q;
	logic [NW-1:0]     n_q;
	logic              ab_ok_q;
	logic              hot_ok_q;
	logic              bad_q;
	logic [AW-1:0]     h_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     j_q;
	logic              pend_q;
	logic [INV_W-1:0]  inv_q;
	logic [AW-1:0]     tp_rd0_q, tp_rd1_q, sa_rd0_q, sa_rd1_q;

	logic [NW-1:0] n_new;
	logic          a_lt_n, b_lt_n, a1_lt_n;
	logic [AW-1:0] a_idx, b_idx, q_pos;
	logic          pair_ok;
	logic          tp_we, sa_we, tp_re, sa_re;
	logic [AW-1:0] tp_waddr, tp_wdata, sa_waddr, sa_wdata;
	logic [AW-1:0] tp_raddr0, tp_raddr1;

	assign n_new   = (int'(list_size) < N_MAX) ? NW'(list_size) : NW'(N_MAX);
	assign a_lt_n  = CMP_W'(index_a) < CMP_W'(n_new);
	assign b_lt_n  = CMP_W'(index_b) < CMP_W'(n_new);
	assign a1_lt_n = (CMP_W'(index_a) + CMP_W'(1)) < CMP_W'(n_new);

	assign a_idx   = AW'(a_raw_q);
	assign b_idx   = AW'(b_raw_q);
	// Neighbor of the moving element for this swap step.
	assign q_pos   = up_q ? (h_q - AW'(1)) : (h_q + AW'(1));
	assign pair_ok = CMP_W'(j_q) < CMP_W'(n_q);

	assign status.cmd      = cmd_q;
	assign status.ab_ok    = ab_ok_q;
	assign status.step_go  = (steps_q != '0) &&
		(up_q ? (h_q != '0) : ((CMP_W'(h_q) + CMP_W'(1)) < CMP_W'(n_q)));
	assign status.cnt_done = !pair_ok;

	// Item capture and per-item control registers.
	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			cmd_q    <= cmd;
			a_raw_q  <= index_a;
			b_raw_q  <= index_b;
			n_q      <= n_new;
			ab_ok_q  <= a_lt_n && b_lt_n;
			hot_ok_q <= a_lt_n;
			h_q      <= AW'(index_a);
			bad_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= CW'(1);
			inv_q    <= '0;
			if (cmd == CMD_TSWAP) begin
				up_q    <= 1'b0;
				steps_q <= a1_lt_n ? STEP_W'(1) : '0;
			end else begin
				up_q    <= move_up;
				steps_q <= a_lt_n ? steps : '0;
			end
		end else begin
			if (op == OP_WR1 && cmd_q == CMD_TSWAP) begin
				bad_q <= sa_rd0_q < sa_rd1_q;
			end
			if (op == OP_WR2) begin
				h_q     <= q_pos;
				steps_q <= steps_q - STEP_W'(1);
			end
			if (op == OP_COUNT && pair_ok) begin
				if ((j_q + CW'(1)) < CW'(n_q)) begin
					j_q <= j_q + CW'(1);
				end else begin
					i_q <= i_q + CW'(1);
					j_q <= i_q + CW'(2);
				end
			end
			if (pend_q && (tp_rd0_q >= tp_rd1_q)) begin
				inv_q <= inv_q + INV_W'(1);
			end
		end
	end

	// One compare is in flight behind each issued pair read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= (op == OP_COUNT) && pair_ok;
		end
	end

	// Write port selection.
	always_comb begin
		tp_we    = 1'b0;
		sa_we    = 1'b0;
		tp_waddr = a_idx;
		tp_wdata = b_idx;
		sa_waddr = a_idx;
		sa_wdata = b_idx;
		unique case (op)
			OP_WR1: begin
				tp_we = 1'b1;
				sa_we = 1'b1;
				priority if (cmd_q == CMD_LOAD) begin
					sa_waddr = a_idx;
					sa_wdata = b_idx;
					tp_waddr = b_idx;
					tp_wdata = a_idx;
				end else if (cmd_q == CMD_ASWAP) begin
					tp_waddr = a_idx;
					tp_wdata = tp_rd1_q;
					sa_waddr = tp_rd1_q;
					sa_wdata = a_idx;
				end else begin
					sa_waddr = h_q;
					sa_wdata = sa_rd1_q;
					tp_waddr = sa_rd1_q;
					tp_wdata = h_q;
				end
			end
			OP_WR2: begin
				tp_we = 1'b1;
				sa_we = 1'b1;
				if (cmd_q == CMD_ASWAP) begin
					tp_waddr = b_idx;
					tp_wdata = tp_rd0_q;
					sa_waddr = tp_rd0_q;
					sa_wdata = b_idx;
				end else begin
					sa_waddr = q_pos;
					sa_wdata = sa_rd0_q;
					tp_waddr = sa_rd0_q;
					tp_wdata = q_pos;
				end
			end
			default: begin
				tp_we = 1'b0;
				sa_we = 1'b0;
			end
		endcase
	end

	assign tp_re     = (op == OP_READ) || (op == OP_COUNT);
	assign sa_re     = (op == OP_READ);
	assign tp_raddr0 = (op == OP_COUNT) ? AW'(i_q) : a_idx;
	assign tp_raddr1 = (op == OP_COUNT) ? AW'(j_q) : b_idx;

	always_ff @(posedge clk) begin
		if (tp_we) begin
			tp_mem[tp_waddr] <= tp_wdata;
		end
		if (tp_re) begin
			tp_rd0_q <= tp_mem[tp_raddr0];
			tp_rd1_q <= tp_mem[tp_raddr1];
		end
	end

	always_ff @(posedge clk) begin
		if (sa_we) begin
			sa_mem[sa_waddr] <= sa_wdata;
		end
		if (sa_re) begin
			sa_rd0_q <= sa_mem[h_q];
			sa_rd1_q <= sa_mem[q_pos];
		end
	end

	assign before_res     = (cmd_q == CMD_COMPARE) && ab_ok_q && (tp_rd0_q < tp_rd1_q);
	assign bad_swap       = (cmd_q == CMD_TSWAP) && bad_q;
	assign final_position = (cmd_q != CMD_HOT) ? '0 :
		(hot_ok_q ? IDX_W'(h_q) : a_raw_q);
	assign inversions     = (cmd_q == CMD_COUNT) ? inv_q : '0;

endmodule

@@ rtl/core/evolving_permutation_table.sv @@
// Top level of the evolving permutation table: config and result registers, controller, datapath.
`timescale 1ns / 1ps

//  channel   | direction | transfer carries
//  ----------+-----------+--------------------------------------------------
//  items     | in        | cmd, index_a, index_b, move_up, steps
//  results   | out       | before_res, bad_swap, final_position, inversions
//  cfg       | in        | list_size write (cfg_we, cfg_wdata), no read-back
//
//  One item is worked at a time; the controller walks each item through
//  registered reads and writes of the two permutation memories. Compare does
//  one pair read; load writes both memories once and answer swap reads, then
//  writes twice (neither writes when an index is out of range); adjacent swap
//  (one move, none out of range) and hot spot do a read and two writes per
//  move; count compares one answer pair per cycle; unused kinds do nothing.
//  The memories have no reset; list_size resets to 64.
//  A new item is taken while a finished result still waits in the output
//  register; only the hand-off of the next result waits for that transfer.

module evolving_permutation_table import ept_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [LS_W-1:0] cfg_wdata,
	ept_in_if.sink          items,
	ept_out_if.source       results
);

	logic [LS_W-1:0]  list_size_q;
	logic             res_valid_q;
	logic             res_before_q;
	logic             res_bad_q;
	logic [IDX_W-1:0] res_fpos_q;
	logic [INV_W-1:0] res_inv_q;

	dp_op_t           op;
	dp_status_t       status;
	logic             done;
	logic             out_free;
	logic             dp_before;
	logic             dp_bad;
	logic [IDX_W-1:0] dp_fpos;
	logic [INV_W-1:0] dp_inv;

	// The working size is list_size, limited by MAX_ITEMS (and at most 127) inside the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_size_q <= LIST_SIZE_RESET;
		end else if (cfg_we) begin
			list_size_q <= cfg_wdata;
		end
	end

	// The output register is free when empty or when its result leaves this cycle.
	assign out_free = !res_valid_q || results.ready;

	ept_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.out_free (out_free),
		.status   (status),
		.in_ready (items.ready),
		.op       (op),
		.done     (done)
	);

	ept_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.cmd            (items.cmd),
		.index_a        (items.index_a),
		.index_b        (items.index_b),
		.move_up        (items.move_up),
		.steps          (items.steps),
		.list_size      (list_size_q),
		.status         (status),
		.before_res     (dp_before),
		.bad_swap       (dp_bad),
		.final_position (dp_fpos),
		.inversions     (dp_inv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload needs no reset; it is only looked at under valid.
	always_ff @(posedge clk) begin
		if (done) begin
			res_before_q <= dp_before;
			res_bad_q    <= dp_bad;
			res_fpos_q   <= dp_fpos;
			res_inv_q    <= dp_inv;
		end
	end

	assign results.valid          = res_valid_q;
	assign results.before_res     = res_before_q;
	assign results.bad_swap       = res_bad_q;
	assign results.final_position = res_fpos_q;
	assign results.inversions     = res_inv_q;

	// A finished item never overwrites a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!res_valid_q || results.ready))
		else $error("result register overwritten before transfer");

	// After an item transfer the block is busy in the next cycle.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> !items.ready)
		else $error("item accepted while the previous one is in work");

	// A pending result only clears through a transfer.
	a_result_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid_q) |-> $past(results.ready))
		else $error("result dropped without a transfer");

	// Completion is only signaled from an idle datapath cycle.
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (op == OP_IDLE))
		else $error("completion while a memory operation is issued");

endmodule
